@@ rtl/flt_pkg.sv @@
// ----------------------------------------------------------------------------
// flt_pkg - shared types and constants for the frame latency monitor
// Stamp layout, nanosecond limits and the stage payload record.
// ----------------------------------------------------------------------------
package flt_pkg;

  localparam int unsigned STAMP_LEN = 10;   // bytes in a transmit stamp
  localparam int unsigned SEC_BYTES = 6;    // big-endian seconds bytes
  localparam int unsigned NS_BYTES  = 4;    // big-endian nanoseconds bytes
  localparam int unsigned CNT_W     = 4;    // width of the in-frame byte count

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [29:0] NS_MAX     = 30'd999999999;

  // Result of the stamp stage, handed to the statistics stage
  typedef struct packed {
    logic        test;
    logic        bad;
    logic [29:0] lat;
  } stamp_res_t;

endpackage

@@ rtl/frame_timestamp_latency_monitor.sv @@
// ----------------------------------------------------------------------------
// frame_timestamp_latency_monitor - embedded timestamp latency monitor
// Extracts a transmit stamp from each frame tail and tracks latency stats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one frame byte per beat, with
//   last_byte marking the end of the frame. rx_seconds and rx_nanoseconds
//   are sampled only on the last beat. The ten bytes ending at the last
//   beat are a big-endian stamp: 48-bit seconds then 32-bit nanoseconds.
//   Output channel (out_valid / out_stall): one result beat per frame,
//   none for other bytes. Min, max and both counters show the running
//   statistics as they stand after that frame.
//   Path: a frame result passes through the stamp stage register, loaded
//   when its last byte is accepted, then the output register, loaded when
//   that is empty or drained. Throughput: one byte per cycle while in_stall
//   is low; the stamp compare and the min/max update are combinational.
//   Stall: while the output register holds an unaccepted result, a further
//   frame result may wait in the stamp stage; in_stall rises only when
//   both are full, so non-final bytes keep flowing otherwise.
//   Reset: clears the stamp buffer, byte count, counters and min/max; no
//   result is pending afterwards.
// ----------------------------------------------------------------------------
module frame_timestamp_latency_monitor #(
  parameter int unsigned COUNTER_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // frame byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [63:0] rx_seconds,
  input  logic [29:0] rx_nanoseconds,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_test_frame,
  output logic        bad_frame,
  output logic [29:0] latency_ns,
  output logic [29:0] min_latency_ns,
  output logic [29:0] max_latency_ns,
  output logic [31:0] total_frame_count,
  output logic [31:0] test_frame_count
);

  // --- state ----------------------------------------------------------------
  logic [7:0]                   tail_bytes [flt_pkg::STAMP_LEN]; // [0] oldest
  logic [7:0]                   tail_next  [flt_pkg::STAMP_LEN];
  logic [flt_pkg::CNT_W-1:0]    bytes_in_frame;
  logic [flt_pkg::CNT_W-1:0]    bytes_next;
  logic [COUNTER_BITS-1:0]      frames_seen;
  logic [COUNTER_BITS-1:0]      test_frames_seen;
  logic [COUNTER_BITS-1:0]      test_frames_next;
  logic [29:0]                  least_latency;
  logic [29:0]                  greatest_latency;

  // stamp stage register
  logic                         s1_valid;
  flt_pkg::stamp_res_t          s1_res;
  flt_pkg::stamp_res_t          s1_res_next;

  // handshake
  logic                         in_acc;
  logic                         out_load;
  logic                         seed;

  // stamp decode
  logic [47:0]                  tx_s;
  logic [31:0]                  tx_ns;
  logic [29:0]                  rx_ns;
  logic [30:0]                  wrap_sum;

  // --- flow control -----------------------------------------------------------
  // Stats stage moves when the output register is empty or being drained.
  assign out_load = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // --- stamp stage: shift tail, decode stamp, subtract -----------------------
  always_comb begin
    for (int i = 0; i < flt_pkg::STAMP_LEN - 1; i++) begin
      tail_next[i] = tail_bytes[i+1];
    end
    tail_next[flt_pkg::STAMP_LEN-1] = data_byte;

    for (int i = 0; i < flt_pkg::SEC_BYTES; i++) begin
      tx_s[47-8*i -: 8] = tail_next[i];
    end
    for (int i = 0; i < flt_pkg::NS_BYTES; i++) begin
      tx_ns[31-8*i -: 8] = tail_next[flt_pkg::SEC_BYTES+i];
    end

    // byte count saturates at the stamp length
    if (bytes_in_frame < flt_pkg::CNT_W'(flt_pkg::STAMP_LEN)) begin
      bytes_next = bytes_in_frame + 1'b1;
    end else begin
      bytes_next = bytes_in_frame;
    end

    // clamp an out-of-range receive nanosecond value
    rx_ns = (rx_nanoseconds > flt_pkg::NS_MAX) ? flt_pkg::NS_MAX : rx_nanoseconds;

    // borrow case: rx_ns + 1e9 - tx_ns, always below 1e9 when taken
    wrap_sum = {1'b0, rx_ns} + {1'b0, flt_pkg::NS_PER_SEC} - {1'b0, tx_ns[29:0]};

    s1_res_next.bad  = (bytes_next < flt_pkg::CNT_W'(flt_pkg::STAMP_LEN)) ||
                       (tx_ns >= {2'b00, flt_pkg::NS_PER_SEC});
    s1_res_next.test = 1'b0;
    s1_res_next.lat  = '0;
    if (!s1_res_next.bad) begin
      if ((rx_seconds == {16'd0, tx_s}) && (rx_ns >= tx_ns[29:0])) begin
        s1_res_next.test = 1'b1;
        s1_res_next.lat  = rx_ns - tx_ns[29:0];
      end else if ((rx_seconds == {15'd0, {1'b0, tx_s} + 49'd1}) &&
                   (rx_ns < tx_ns[29:0])) begin
        s1_res_next.test = 1'b1;
        s1_res_next.lat  = wrap_sum[29:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < flt_pkg::STAMP_LEN; i++) begin
        tail_bytes[i] <= '0;
      end
      bytes_in_frame <= '0;
      s1_valid       <= 1'b0;
    end else begin
      if (in_acc) begin
        tail_bytes     <= tail_next;
        bytes_in_frame <= last_byte ? '0 : bytes_next;
        s1_valid       <= last_byte;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_byte) begin
      s1_res <= s1_res_next;
    end
  end

  // --- statistics stage --------------------------------------------------------
  // Counters and min/max only change on a load, so they drive the ports directly.
  assign test_frames_next = test_frames_seen + COUNTER_BITS'(1);
  assign seed             = test_frames_next <= COUNTER_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen      <= '0;
      test_frames_seen <= '0;
      least_latency    <= '0;
      greatest_latency <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid   <= 1'b1;
        frames_seen <= frames_seen + COUNTER_BITS'(1);
        if (s1_res.test) begin
          test_frames_seen <= test_frames_next;
          if (seed || (s1_res.lat > greatest_latency)) begin
            greatest_latency <= s1_res.lat;
          end
          if (seed || (s1_res.lat < least_latency)) begin
            least_latency <= s1_res.lat;
          end
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      is_test_frame <= s1_res.test;
      bad_frame     <= s1_res.bad;
      latency_ns    <= s1_res.lat;
    end
  end

  assign min_latency_ns    = least_latency;
  assign max_latency_ns    = greatest_latency;
  assign total_frame_count = 32'(frames_seen);
  assign test_frame_count  = 32'(test_frames_seen);

endmodule

@@ rtl/flt_checker.sv @@
// ----------------------------------------------------------------------------
// flt_checker - port-level checks for the frame latency monitor
// Watches the result channel and the statistics it reports.
// ----------------------------------------------------------------------------
module flt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        is_test_frame,
  input logic        bad_frame,
  input logic [29:0] latency_ns,
  input logic [29:0] min_latency_ns,
  input logic [29:0] max_latency_ns
);

  // no result is pending straight after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat pending after reset");

  // a flagged frame can never count as a test frame
  a_bad_not_test: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_test_frame && bad_frame))
    else $error("frame both bad and test");

  // a test frame's latency lies within the running min/max, below one second
  a_lat_bounds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_test_frame) |->
      (min_latency_ns <= latency_ns) && (latency_ns <= max_latency_ns) &&
      (max_latency_ns <= flt_pkg::NS_MAX))
    else $error("test latency outside min/max");

  // latency reads zero on frames that are not test frames
  a_lat_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_test_frame) |-> (latency_ns == '0))
    else $error("latency set on non-test frame");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(latency_ns) &&
      $stable(min_latency_ns) && $stable(max_latency_ns))
    else $error("stalled result beat changed");

endmodule

bind frame_timestamp_latency_monitor flt_checker u_flt_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .is_test_frame  (is_test_frame),
  .bad_frame      (bad_frame),
  .latency_ns     (latency_ns),
  .min_latency_ns (min_latency_ns),
  .max_latency_ns (max_latency_ns)
);
